### src/thermal_effect_strength_limiter_top_assert.svh
// Assertion macros for the thermal effect strength limiter.
`ifndef THERMAL_EFFECT_STRENGTH_LIMITER_TOP_ASSERT_SVH
`define THERMAL_EFFECT_STRENGTH_LIMITER_TOP_ASSERT_SVH

// Same-cycle implication: whenever ante holds, cons holds too.
`define TESL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("limiter assertion failed");

// Next-cycle implication: when ante holds, cons holds on the following clock.
`define TESL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("limiter assertion failed");

`endif

### src/tesl_pkg.sv
package tesl_pkg;

    // Limiter modes; code 3 is never produced
    typedef enum logic [1:0] {
        MODE_INACTIVE = 2'd0,
        MODE_STANDARD = 2'd1,
        MODE_AUX      = 2'd2
    } mode_t;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_THR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ENGAGE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT     = 3'd5;

    localparam int unsigned CFG_DATA_W = 32;

    // Register reset values (Q9.4 for temperatures)
    localparam logic        [3:0]  RST_PHASE_THR = 4'd0;
    localparam logic        [31:0] RST_DELAY     = 32'd0;
    localparam logic signed [6:0]  RST_OFFSET    = 7'sd0;
    localparam logic signed [13:0] RST_ENGAGE    = 14'sd1840;
    localparam logic signed [13:0] RST_RELEASE   = 14'sd1600;
    localparam logic        [7:0]  RST_LIMIT     = 8'd10;

    // Auxiliary release base, whole degrees
    localparam logic [9:0] AUX_BASE_DEG = 10'd115;

    typedef struct packed {
        logic signed [13:0] motor_temp;
        logic               aux_active;
        logic        [3:0]  controller_phase;
        logic        [31:0] deadline_ms;
        logic        [31:0] now_time_ms;
        logic        [7:0]  force_in;
        logic        [7:0]  spring_in;
        logic        [7:0]  damper_in;
    } in_word_t;

    typedef struct packed {
        logic [7:0] force_out;
        logic [7:0] spring_out;
        logic [7:0] damper_out;
        logic       limit_flag;
        logic [1:0] limit_mode;
    } out_word_t;

    typedef struct packed {
        logic        [3:0]  aux_phase_threshold;
        logic        [31:0] aux_delay_ms;
        logic signed [6:0]  aux_release_offset;
        logic signed [13:0] engage_temp;
        logic signed [13:0] release_temp;
        logic        [7:0]  strength_limit;
    } cfg_t;

    typedef struct packed {
        mode_t      mode;
        logic [7:0] saved_force;
        logic [7:0] saved_spring;
        logic [7:0] saved_damper;
        logic       active_flag;
    } lim_state_t;

endpackage

### src/tesl_ifs.sv
// Input tick channel
interface tesl_in_if;
    logic               valid;
    logic               ready;
    tesl_pkg::in_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// Result channel
interface tesl_out_if;
    logic                valid;
    logic                ready;
    tesl_pkg::out_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// Configuration write channel
interface tesl_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [tesl_pkg::CFG_IDX_W-1:0]   index;
    logic [tesl_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### src/thermal_effect_strength_limiter_top.sv
// Thermal effect strength limiter.
// A tick word is accepted into the input register; its result word is then
// written to the result register behind the decision logic.
// Throughput: one word per cycle unless a low result.ready stalls the output; the only loop is the state register.
// Reset (rst_n, async, active low) clears mode, snapshot and flag and loads
// the register defaults; no clearing pass.
`include "thermal_effect_strength_limiter_top_assert.svh"

module thermal_effect_strength_limiter_top (
    input  logic        clk,
    input  logic        rst_n,
    tesl_in_if.sink     tick,
    tesl_out_if.source  result,
    tesl_cfg_if.sink    cfg
);

    tesl_pkg::cfg_t       cfg_reg;
    tesl_pkg::in_word_t   in_reg;
    logic                 in_valid_reg;
    tesl_pkg::lim_state_t st_reg;
    tesl_pkg::lim_state_t st_next;
    tesl_pkg::out_word_t  out_reg;
    tesl_pkg::out_word_t  out_next;
    logic                 out_valid_reg;
    logic                 adv;
    logic                 st_idle;
    logic                 st_engaged;

    // Configuration writes are always taken
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.aux_phase_threshold <= tesl_pkg::RST_PHASE_THR;
            cfg_reg.aux_delay_ms        <= tesl_pkg::RST_DELAY;
            cfg_reg.aux_release_offset  <= tesl_pkg::RST_OFFSET;
            cfg_reg.engage_temp         <= tesl_pkg::RST_ENGAGE;
            cfg_reg.release_temp        <= tesl_pkg::RST_RELEASE;
            cfg_reg.strength_limit      <= tesl_pkg::RST_LIMIT;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                tesl_pkg::CFG_PHASE_THR: cfg_reg.aux_phase_threshold <= cfg.data[3:0];
                tesl_pkg::CFG_DELAY:     cfg_reg.aux_delay_ms        <= cfg.data[31:0];
                tesl_pkg::CFG_OFFSET:    cfg_reg.aux_release_offset  <= $signed(cfg.data[6:0]);
                tesl_pkg::CFG_ENGAGE:    cfg_reg.engage_temp         <= $signed(cfg.data[13:0]);
                tesl_pkg::CFG_RELEASE:   cfg_reg.release_temp        <= $signed(cfg.data[13:0]);
                tesl_pkg::CFG_LIMIT:     cfg_reg.strength_limit      <= cfg.data[7:0];
                default:                 ;
            endcase
        end
    end

    // Advance the held tick when the result register is free or being drained
    assign adv        = in_valid_reg && (!out_valid_reg || result.ready);
    assign tick.ready = !in_valid_reg || adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (tick.ready)
        begin
            in_valid_reg <= tick.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick.ready && tick.valid)
        begin
            in_reg <= tick.data;
        end
    end

    tesl_core u_core (
        .cfg     (cfg_reg),
        .st      (st_reg),
        .word    (in_reg),
        .st_next (st_next),
        .res     (out_next)
    );

    // Commit state and result together
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.mode         <= tesl_pkg::MODE_INACTIVE;
            st_reg.saved_force  <= 8'd0;
            st_reg.saved_spring <= 8'd0;
            st_reg.saved_damper <= 8'd0;
            st_reg.active_flag  <= 1'b0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                st_reg <= st_next;
            end
            out_valid_reg <= adv || (out_valid_reg && !result.ready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= out_next;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;

    // Decode the committed mode for the checks below
    assign st_idle    = (st_reg.mode == tesl_pkg::MODE_INACTIVE);
    assign st_engaged = (st_reg.mode == tesl_pkg::MODE_STANDARD)
                        || (st_reg.mode == tesl_pkg::MODE_AUX);

    // Held result always reports the committed mode
    `TESL_ASSERT_IMP(a_mode_match, clk, rst_n, out_valid_reg, out_reg.limit_mode == st_reg.mode)
    // An advanced tick always lands in the result register
    `TESL_ASSERT_NXT(a_adv_lands, clk, rst_n, adv, out_valid_reg)
    // Inactive tick clears the flag; engaged tick sets it
    `TESL_ASSERT_NXT(a_flag_rule, clk, rst_n, adv && st_idle, !out_reg.limit_flag)
    `TESL_ASSERT_NXT(a_flag_set, clk, rst_n, adv && st_engaged, out_reg.limit_flag)

endmodule

### src/tesl_core.sv
// Per-tick decision: mode transition, snapshot, clamp and restore.
module tesl_core (
    input  tesl_pkg::cfg_t       cfg,
    input  tesl_pkg::lim_state_t st,
    input  tesl_pkg::in_word_t   word,
    output tesl_pkg::lim_state_t st_next,
    output tesl_pkg::out_word_t  res
);

    logic        [31:0] due;
    logic        [9:0]  aux_deg;
    logic signed [13:0] aux_rel;
    logic signed [13:0] rel;
    logic               aux_go;
    logic               std_go;
    logic               release_hit;
    logic        [7:0]  f_clamp;
    logic        [7:0]  s_clamp;
    logic        [7:0]  d_clamp;

    // Auxiliary engage: phase past threshold and time past deadline plus delay
    assign due    = word.deadline_ms + cfg.aux_delay_ms;
    assign aux_go = (word.controller_phase > cfg.aux_phase_threshold)
                    && (word.now_time_ms > due);
    assign std_go = $signed(word.motor_temp) > $signed(cfg.engage_temp);

    // Auxiliary release temperature in Q9.4: (115 + offset) * 16
    assign aux_deg = {{3{cfg.aux_release_offset[6]}}, cfg.aux_release_offset}
                     + tesl_pkg::AUX_BASE_DEG;
    assign aux_rel = $signed({aux_deg, 4'b0000});
    assign rel     = (st.mode == tesl_pkg::MODE_STANDARD) ? cfg.release_temp : aux_rel;
    assign release_hit = $signed(word.motor_temp) < $signed(rel);

    // Clamp each strength to the ceiling
    assign f_clamp = (word.force_in  > cfg.strength_limit) ? cfg.strength_limit : word.force_in;
    assign s_clamp = (word.spring_in > cfg.strength_limit) ? cfg.strength_limit : word.spring_in;
    assign d_clamp = (word.damper_in > cfg.strength_limit) ? cfg.strength_limit : word.damper_in;

    always_comb
    begin
        st_next        = st;
        res.force_out  = word.force_in;
        res.spring_out = word.spring_in;
        res.damper_out = word.damper_in;
        unique case (st.mode)
            tesl_pkg::MODE_INACTIVE:
            begin
                // Engage and snapshot, strengths pass through
                if (word.aux_active ? aux_go : std_go)
                begin
                    st_next.mode = word.aux_active ? tesl_pkg::MODE_AUX
                                                   : tesl_pkg::MODE_STANDARD;
                    st_next.saved_force  = word.force_in;
                    st_next.saved_spring = word.spring_in;
                    st_next.saved_damper = word.damper_in;
                end
                st_next.active_flag = 1'b0;
            end
            tesl_pkg::MODE_STANDARD, tesl_pkg::MODE_AUX:
            begin
                st_next.active_flag = 1'b1;
                if (release_hit)
                begin
                    // Release: restore the snapshot
                    st_next.mode   = tesl_pkg::MODE_INACTIVE;
                    res.force_out  = st.saved_force;
                    res.spring_out = st.saved_spring;
                    res.damper_out = st.saved_damper;
                end
                else
                begin
                    res.force_out  = f_clamp;
                    res.spring_out = s_clamp;
                    res.damper_out = d_clamp;
                end
            end
            default:
            begin
                // Unused code: drop back to inactive, keep the flag
                st_next.mode = tesl_pkg::MODE_INACTIVE;
            end
        endcase
        res.limit_flag = st_next.active_flag;
        res.limit_mode = st_next.mode;
    end

endmodule
